// File: sv/alcm_pkg.sv
// shared constants, widths and types of the alc meter moving average
package alcm_pkg;

  localparam int WINDOW_LEN = 200;

  localparam int GAIN_W  = 16;
  localparam int VALUE_W = 10;
  localparam int LIMIT_W = 8;

  localparam int ONE_Q15   = 32768;
  localparam int Q_FRAC    = 15;
  localparam int SCALE_NUM = 1500;
  localparam int VALUE_MOD = 1000;

  localparam int HOLDOFF_RESET = 20;
  localparam int HOLDOFF_MAX   = (1 << LIMIT_W) - 1;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = LIMIT_W;

  localparam logic [CFG_IDX_W-1:0] CFG_REPORT_ENABLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF_LIMIT = 1'd1;

  localparam int PTR_W  = $clog2(WINDOW_LEN);
  localparam int SUM_W  = $clog2(WINDOW_LEN * ONE_Q15 + 1);
  localparam int N_W    = $clog2(SCALE_NUM * WINDOW_LEN + 1);
  localparam int PROD_W = N_W + Q_FRAC;
  localparam int CNT_W  = $clog2(PROD_W);
  localparam int ACC_W  = $clog2(SCALE_NUM);
  localparam int QUO_W  = $clog2(SCALE_NUM + 1);
  localparam int REM_W  = (WINDOW_LEN > 2) ? $clog2(WINDOW_LEN) : 1;

  typedef struct packed {
    logic               done;
    logic [VALUE_W-1:0] value;
  } meter_res_t;

endpackage

// File: sv/alc_meter_moving_average.sv
// Boxcar moving average of the ALC gain over WINDOW_LEN transmit ticks, turned into a meter
// value 0..999; an ordinary transmit tick reports it only on change once the holdoff count is
// reached. An idle tick that reports 0 and the first transmit tick go straight to the emit state
// (the window refill needs no sweep: entries not yet rewritten since the refill read as 1.0);
// an idle tick that reports nothing needs no further state. An ordinary transmit tick reads the
// window, then runs the bit-serial multiply by 1500 and the restoring division by the window
// length, and passes through the emit state when it reports. A reporting beat also waits
// while the output register still holds an unaccepted result. A waiting result sits in the
// output register while the next beat is taken.
module alc_meter_moving_average
  import alcm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  tx_active_i,
  input  logic [GAIN_W-1:0]     gain_sample_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [VALUE_W-1:0]    meter_value_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_CALC = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [GAIN_W-1:0]  gain_q, gain_d;
  logic [PTR_W-1:0]   ptr_q, ptr_d;
  logic               wrapped_q, wrapped_d;
  logic [SUM_W-1:0]   deficit_q, deficit_d;
  logic               pending_q, pending_d;
  logic [VALUE_W-1:0] last_q, last_d;
  logic [LIMIT_W-1:0] hold_q, hold_d;
  logic               enable_q, enable_d;
  logic [LIMIT_W-1:0] limit_q, limit_d;
  logic [VALUE_W-1:0] emit_q, emit_d;
  logic               out_valid_q, out_valid_d;
  logic [VALUE_W-1:0] out_value_q, out_value_d;

  logic               accept;
  logic               ram_re;
  logic               ram_we;
  logic [GAIN_W-1:0]  ram_rdata;
  logic [GAIN_W-1:0]  old_sample;
  logic [SUM_W:0]     deficit_upd;
  logic [SUM_W-1:0]   deficit_new;
  logic               meter_start;
  meter_res_t         meter_res;
  logic [LIMIT_W-1:0] hold_inc;

  assign in_ready_o = state_q == S_IDLE;
  assign accept     = in_valid_i & in_ready_o;
  assign ram_re     = accept & tx_active_i & ~pending_q;
  assign ram_we     = state_q == S_READ;
  assign meter_start = state_q == S_READ;

  assign old_sample  = wrapped_q ? ram_rdata : GAIN_W'(ONE_Q15);
  // deficit is WINDOW_LEN * 1.0 minus the window sum
  assign deficit_upd = {1'b0, deficit_q} + (SUM_W+1)'(old_sample) - (SUM_W+1)'(gain_q);
  assign deficit_new = SUM_W'(deficit_upd);
  assign hold_inc    = (hold_q == LIMIT_W'(HOLDOFF_MAX)) ? hold_q : hold_q + 1'b1;

  alcm_ram #(
    .WIDTH(GAIN_W),
    .DEPTH(WINDOW_LEN)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ptr_q),
    .wdata_i (gain_q),
    .re_i    (ram_re),
    .raddr_i (ptr_q),
    .rdata_o (ram_rdata)
  );

  alcm_serial_meter u_meter (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (meter_start),
    .deficit_i (deficit_new),
    .res_o     (meter_res)
  );

  always_comb begin
    state_d     = state_q;
    gain_d      = gain_q;
    ptr_d       = ptr_q;
    wrapped_d   = wrapped_q;
    deficit_d   = deficit_q;
    pending_d   = pending_q;
    last_d      = last_q;
    hold_d      = hold_q;
    enable_d    = enable_q;
    limit_d     = limit_q;
    emit_d      = emit_q;
    out_valid_d = out_valid_q;
    out_value_d = out_value_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (!tx_active_i) begin
            pending_d = 1'b1;
            if (hold_q >= limit_q) begin
              emit_d  = '0;
              state_d = S_EMIT;
            end
          end else if (pending_q) begin
            // refill: window reads as all 1.0, meter value is zero
            ptr_d     = '0;
            wrapped_d = 1'b0;
            deficit_d = '0;
            pending_d = 1'b0;
            emit_d    = '0;
            state_d   = S_EMIT;
            hold_d    = (last_q != '0) ? LIMIT_W'(1) : '0;
            if (last_q != '0 && limit_q == '0) begin
              last_d = '0;
            end
          end else begin
            gain_d  = (gain_sample_i >= GAIN_W'(ONE_Q15)) ? GAIN_W'(ONE_Q15) : gain_sample_i;
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        deficit_d = deficit_new;
        if (ptr_q == PTR_W'(WINDOW_LEN - 1)) begin
          ptr_d     = '0;
          wrapped_d = 1'b1;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
        state_d = S_CALC;
      end
      S_CALC: begin
        if (meter_res.done) begin
          state_d = S_IDLE;
          if (meter_res.value != last_q) begin
            hold_d = hold_inc;
            if (hold_q >= limit_q) begin
              last_d = meter_res.value;
              if (enable_q) begin
                emit_d  = meter_res.value;
                state_d = S_EMIT;
              end
            end
          end
        end
      end
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_value_d = emit_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_REPORT_ENABLE: enable_d = cfg_wdata_i[0];
        CFG_HOLDOFF_LIMIT: limit_d  = cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ptr_q       <= '0;
      wrapped_q   <= 1'b0;
      deficit_q   <= '0;
      pending_q   <= 1'b1;
      last_q      <= '0;
      hold_q      <= '0;
      enable_q    <= 1'b1;
      limit_q     <= LIMIT_W'(HOLDOFF_RESET);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      wrapped_q   <= wrapped_d;
      deficit_q   <= deficit_d;
      pending_q   <= pending_d;
      last_q      <= last_d;
      hold_q      <= hold_d;
      enable_q    <= enable_d;
      limit_q     <= limit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gain_q      <= gain_d;
    emit_q      <= emit_d;
    out_value_q <= out_value_d;
  end

  assign out_valid_o   = out_valid_q;
  assign meter_value_o = out_value_q;

endmodule

// File: sv/alcm_ram.sv
// generic single write port ram with registered read
module alcm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 200
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/alcm_serial_meter.sv
// bit-serial scale by 1500, restoring divide by window length, mod 1000
module alcm_serial_meter
  import alcm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SUM_W-1:0] deficit_i,
  output meter_res_t       res_o
);

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_MUL  = 2'd1;
  localparam logic [1:0] M_DIV  = 2'd2;
  localparam logic [1:0] M_FIN  = 2'd3;

  logic [1:0]       phase_q, phase_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [SUM_W-1:0] dsh_q, dsh_d;
  logic [ACC_W-1:0] acc_q, acc_d;
  logic [N_W-1:0]   nsh_q, nsh_d;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [QUO_W-1:0] quo_q, quo_d;

  logic [ACC_W:0]   mul_sum;
  logic [REM_W:0]   div_t;
  logic             div_ge;
  logic [QUO_W-1:0] quo_mod;

  assign mul_sum = {1'b0, acc_q} + (dsh_q[0] ? (ACC_W+1)'(SCALE_NUM) : '0);
  assign div_t   = {rem_q, nsh_q[N_W-1]};
  assign div_ge  = div_t >= (REM_W+1)'(WINDOW_LEN);
  assign quo_mod = (quo_q >= QUO_W'(VALUE_MOD)) ? quo_q - QUO_W'(VALUE_MOD) : quo_q;

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    dsh_d   = dsh_q;
    acc_d   = acc_q;
    nsh_d   = nsh_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    case (phase_q)
      M_IDLE: begin
        if (start_i) begin
          dsh_d   = deficit_i;
          acc_d   = '0;
          cnt_d   = CNT_W'(PROD_W - 1);
          phase_d = M_MUL;
        end
      end
      M_MUL: begin
        // product leaves lsb first, the top N_W bits stay in nsh
        dsh_d = dsh_q >> 1;
        acc_d = mul_sum[ACC_W:1];
        nsh_d = {mul_sum[0], nsh_q[N_W-1:1]};
        if (cnt_q == '0) begin
          rem_d   = '0;
          quo_d   = '0;
          cnt_d   = CNT_W'(N_W - 1);
          phase_d = M_DIV;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      M_DIV: begin
        nsh_d = nsh_q << 1;
        rem_d = div_ge ? REM_W'(div_t - (REM_W+1)'(WINDOW_LEN)) : REM_W'(div_t);
        quo_d = {quo_q[QUO_W-2:0], div_ge};
        if (cnt_q == '0) begin
          phase_d = M_FIN;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      M_FIN: begin
        phase_d = M_IDLE;
      end
      default: begin
        phase_d = M_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= M_IDLE;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dsh_q <= dsh_d;
    acc_q <= acc_d;
    nsh_q <= nsh_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign res_o.done  = phase_q == M_FIN;
  assign res_o.value = VALUE_W'(quo_mod);

endmodule

// File: sv/alcm_checker.sv
// port-level checks of the alc meter, bound to the top level
module alcm_checker
  import alcm_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               tx_active_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [VALUE_W-1:0] meter_value_o
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(meter_value_o))
    else $error("result beat dropped or changed while stalled");

  a_value_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> meter_value_o < VALUE_W'(VALUE_MOD))
    else $error("meter value out of range");

  // in the cycle after a transmit beat the block is always busy
  a_tx_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && tx_active_i |=> !in_ready_o)
    else $error("input ready right after a transmit beat");

  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without the block being busy");

endmodule

bind alc_meter_moving_average alcm_checker u_alcm_checker (.*);
